### hw/rtl/pvcm_pkg.sv
// pvcm_pkg: types, constants and codes shared by the velocity command mux
// used by the channel interfaces and every rtl module of the block
`default_nettype none

package pvcm_pkg;

  localparam int NUM_SOURCES = 4;
  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  localparam int VEL_W = 16;
  localparam int DB_W = 15;
  localparam int AGE_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // reset values of the configuration registers
  localparam logic [DB_W-1:0] LIN_DB_RST = DB_W'(41);
  localparam logic [DB_W-1:0] ANG_DB_RST = DB_W'(41);
  localparam logic [AGE_W-1:0] TIMEOUT_RST = AGE_W'(200);

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [SRC_W-1:0] src_idx_t;

  typedef enum logic [1:0] {
    KIND_CMD = 2'd0,
    KIND_TICK = 2'd1,
    KIND_PUBLISH = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIN_DB = 2'd0,
    CFG_ANG_DB = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    vel_t linear_x;
    vel_t linear_y;
    vel_t linear_z;
    vel_t angular_x;
    vel_t angular_y;
    vel_t angular_z;
  } vel6_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] source;
    vel6_t vel;
  } item_t;

  // control from the request decode to the source bank
  typedef struct packed {
    logic store;
    src_idx_t idx;
    logic tick;
  } bank_ctl_t;

  typedef struct packed {
    logic valid;
    logic [1:0] source;
    vel6_t vel;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/pvcm_in_if.sv
// pvcm_in_if: request channel of the velocity command mux, valid/ready with payload
// depends on pvcm_pkg
`default_nettype none

interface pvcm_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [1:0] src;
  pvcm_pkg::vel_t linear_x;
  pvcm_pkg::vel_t linear_y;
  pvcm_pkg::vel_t linear_z;
  pvcm_pkg::vel_t angular_x;
  pvcm_pkg::vel_t angular_y;
  pvcm_pkg::vel_t angular_z;

  modport source (
    output valid, kind, src, linear_x, linear_y, linear_z,
           angular_x, angular_y, angular_z,
    input ready
  );
  modport sink (
    input valid, kind, src, linear_x, linear_y, linear_z,
          angular_x, angular_y, angular_z,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/pvcm_out_if.sv
// pvcm_out_if: result channel of the velocity command mux, valid/ready with payload
// depends on pvcm_pkg
`default_nettype none

interface pvcm_out_if;
  logic valid;
  logic ready;
  logic out_valid;
  logic [1:0] out_source;
  pvcm_pkg::vel_t out_linear_x;
  pvcm_pkg::vel_t out_linear_y;
  pvcm_pkg::vel_t out_linear_z;
  pvcm_pkg::vel_t out_angular_x;
  pvcm_pkg::vel_t out_angular_y;
  pvcm_pkg::vel_t out_angular_z;

  modport source (
    output valid, out_valid, out_source, out_linear_x, out_linear_y, out_linear_z,
           out_angular_x, out_angular_y, out_angular_z,
    input ready
  );
  modport sink (
    input valid, out_valid, out_source, out_linear_x, out_linear_y, out_linear_z,
          out_angular_x, out_angular_y, out_angular_z,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/pvcm_src_bank.sv
// pvcm_src_bank: per-source stored velocity and saturating age counters
// depends on pvcm_pkg
`default_nettype none

module pvcm_src_bank (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pvcm_pkg::bank_ctl_t ctl,
  input  wire pvcm_pkg::vel6_t     cmd_vel,
  output pvcm_pkg::vel6_t          stored_vel [pvcm_pkg::NUM_SOURCES],
  output pvcm_pkg::age_t           age        [pvcm_pkg::NUM_SOURCES]
);

  pvcm_pkg::vel6_t vel_r [pvcm_pkg::NUM_SOURCES];
  pvcm_pkg::age_t  age_r [pvcm_pkg::NUM_SOURCES];

  // velocity only matters once its source has been refreshed, so no reset
  always_ff @(posedge clk) begin
    if (ctl.store) begin
      vel_r[ctl.idx] <= cmd_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pvcm_pkg::NUM_SOURCES; i++) begin
        age_r[i] <= pvcm_pkg::AGE_MAX;
      end
    end else begin
      for (int i = 0; i < pvcm_pkg::NUM_SOURCES; i++) begin
        if (ctl.store && (ctl.idx == pvcm_pkg::src_idx_t'(i))) begin
          age_r[i] <= '0;
        end else if (ctl.tick && (age_r[i] != pvcm_pkg::AGE_MAX)) begin
          age_r[i] <= age_r[i] + pvcm_pkg::age_t'(1);
        end
      end
    end
  end

  assign stored_vel = vel_r;
  assign age = age_r;

endmodule

`default_nettype wire

### hw/rtl/pvcm_select.sv
// pvcm_select: priority pick of the highest-priority fresh source
// depends on pvcm_pkg
`default_nettype none

module pvcm_select (
  input  wire pvcm_pkg::vel6_t stored_vel [pvcm_pkg::NUM_SOURCES],
  input  wire pvcm_pkg::age_t  age        [pvcm_pkg::NUM_SOURCES],
  input  wire pvcm_pkg::age_t  timeout,
  output pvcm_pkg::result_t    res
);

  // scan from lowest priority up so source 0 wins last
  always_comb begin
    res = '0;
    for (int i = pvcm_pkg::NUM_SOURCES - 1; i >= 0; i--) begin
      if (age[i] < timeout) begin
        res.valid = 1'b1;
        res.source = 2'(i);
        res.vel = stored_vel[i];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/priority_velocity_command_mux_core.sv
// priority_velocity_command_mux_core: top level of the priority velocity command mux
// depends on pvcm_pkg, pvcm_in_if, pvcm_out_if, pvcm_src_bank, pvcm_select
`default_nettype none

// usage
// - in_chan carries requests: kind 0 is a velocity command from a source
//   (0 joystick, highest priority, to 3 navigation), kind 1 a time tick,
//   kind 2 a publish request; kind 3 is dropped
// - a command is kept, and its source made fresh, only when |linear_x| or
//   |angular_z| is above its deadband; ticks age all sources, saturating
// - each publish gives one result on out_chan: the highest-priority source
//   whose age is below timeout_ticks, or out_valid 0 with zero speeds
// - cfg_we/cfg_index/cfg_wdata write the deadbands and timeout; write only
//   while no request is in flight
// - order: a request taken at one edge is decoded from the input register
//   in the next cycle; a publish result is registered in the result register
//   when the publish leaves the input register, and is on out_chan from then on
// - throughput: one request per cycle while no publish waits on a stalled
//   result, limited by the single input register and single result register
// - a stalled result holds the result register; commands and ticks still
//   drain behind it, and a publish waits in the input register
// - after reset all sources are stale and configuration is at defaults

module priority_velocity_command_mux_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pvcm_in_if.sink                            in_chan,
  pvcm_out_if.source                         out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [pvcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pvcm_pkg::CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [pvcm_pkg::DB_W-1:0] lin_db_r;
  logic [pvcm_pkg::DB_W-1:0] ang_db_r;
  pvcm_pkg::age_t            timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_db_r <= pvcm_pkg::LIN_DB_RST;
      ang_db_r <= pvcm_pkg::ANG_DB_RST;
      timeout_r <= pvcm_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (pvcm_pkg::cfg_idx_t'(cfg_index))
        pvcm_pkg::CFG_LIN_DB:  lin_db_r <= cfg_wdata[pvcm_pkg::DB_W-1:0];
        pvcm_pkg::CFG_ANG_DB:  ang_db_r <= cfg_wdata[pvcm_pkg::DB_W-1:0];
        pvcm_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata[pvcm_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic            req_valid_r;
  pvcm_pkg::item_t req_r;
  logic            req_adv;
  logic            req_is_pub;
  logic            res_valid_r;
  pvcm_pkg::result_t res_r;

  assign req_is_pub = (pvcm_pkg::kind_t'(req_r.kind) == pvcm_pkg::KIND_PUBLISH);
  // a publish can leave only when the result register is free or being drained
  assign req_adv = req_valid_r && (!req_is_pub || !res_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || req_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      req_r.kind <= in_chan.kind;
      req_r.source <= in_chan.src;
      req_r.vel.linear_x <= in_chan.linear_x;
      req_r.vel.linear_y <= in_chan.linear_y;
      req_r.vel.linear_z <= in_chan.linear_z;
      req_r.vel.angular_x <= in_chan.angular_x;
      req_r.vel.angular_y <= in_chan.angular_y;
      req_r.vel.angular_z <= in_chan.angular_z;
    end
  end

  // deadband check: magnitude is 17 bits so that -32768 gives 32768
  logic [pvcm_pkg::VEL_W:0] lin_mag;
  logic [pvcm_pkg::VEL_W:0] ang_mag;
  logic                     above_db;
  logic                     src_ok;
  pvcm_pkg::bank_ctl_t      bank_ctl;

  always_comb begin
    lin_mag = req_r.vel.linear_x[pvcm_pkg::VEL_W-1]
            ? ((pvcm_pkg::VEL_W+1)'(1) << pvcm_pkg::VEL_W) - {1'b0, req_r.vel.linear_x}
            : {1'b0, req_r.vel.linear_x};
    ang_mag = req_r.vel.angular_z[pvcm_pkg::VEL_W-1]
            ? ((pvcm_pkg::VEL_W+1)'(1) << pvcm_pkg::VEL_W) - {1'b0, req_r.vel.angular_z}
            : {1'b0, req_r.vel.angular_z};
    above_db = (lin_mag > (pvcm_pkg::VEL_W+1)'(lin_db_r))
            || (ang_mag > (pvcm_pkg::VEL_W+1)'(ang_db_r));
    // commands naming a source past the configured count are dropped
    src_ok = (int'(req_r.source) < pvcm_pkg::NUM_SOURCES);
    bank_ctl = '0;
    bank_ctl.idx = pvcm_pkg::src_idx_t'(req_r.source);
    if (req_adv) begin
      unique case (pvcm_pkg::kind_t'(req_r.kind))
        pvcm_pkg::KIND_CMD:  bank_ctl.store = src_ok && above_db;
        pvcm_pkg::KIND_TICK: bank_ctl.tick = 1'b1;
        default: ;
      endcase
    end
  end

  pvcm_pkg::vel6_t   stored_vel [pvcm_pkg::NUM_SOURCES];
  pvcm_pkg::age_t    src_age    [pvcm_pkg::NUM_SOURCES];
  pvcm_pkg::result_t sel_res;

  pvcm_src_bank u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (bank_ctl),
    .cmd_vel    (req_r.vel),
    .stored_vel (stored_vel),
    .age        (src_age)
  );

  pvcm_select u_select (
    .stored_vel (stored_vel),
    .age        (src_age),
    .timeout    (timeout_r),
    .res        (sel_res)
  );

  // result register
  logic res_load;
  assign res_load = req_adv && req_is_pub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= sel_res;
    end
  end

  assign out_chan.valid = res_valid_r;
  assign out_chan.out_valid = res_r.valid;
  assign out_chan.out_source = res_r.source;
  assign out_chan.out_linear_x = res_r.vel.linear_x;
  assign out_chan.out_linear_y = res_r.vel.linear_y;
  assign out_chan.out_linear_z = res_r.vel.linear_z;
  assign out_chan.out_angular_x = res_r.vel.angular_x;
  assign out_chan.out_angular_y = res_r.vel.angular_y;
  assign out_chan.out_angular_z = res_r.vel.angular_z;

endmodule

`default_nettype wire

### tb/pvcm_mux_checker.sv
// pvcm_mux_checker: watches the request and result channels of the velocity command mux,
// keeps its own copy of the sources and registers and checks every published result
// depends on pvcm_pkg, pvcm_in_if, pvcm_out_if
`default_nettype none

module pvcm_mux_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pvcm_in_if                                  in_mon,
  pvcm_out_if                                 out_mon,
  input  wire logic                           cfg_we,
  input  wire logic [pvcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pvcm_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  mismatch_cnt,
  output int                                  publish_pending
);
  import pvcm_pkg::*;

  vel6_t           src_vel [NUM_SOURCES];
  age_t            src_age [NUM_SOURCES];
  logic [DB_W-1:0] lin_band;
  logic [DB_W-1:0] ang_band;
  age_t            stale_after;
  result_t         publish_q [$];

  // magnitude of a q4.12 value, one bit wider so that the most negative value fits
  function automatic logic [VEL_W:0] vel_mag(input vel_t v);
    logic signed [VEL_W:0] wide;
    wide = v;
    return (wide < 0) ? -wide : wide;
  endfunction

  task automatic clear_sources();
    int i;
    for (i = 0; i < NUM_SOURCES; i++) begin
      src_vel[i] = '0;
      src_age[i] = AGE_MAX;
    end
    lin_band = LIN_DB_RST;
    ang_band = ANG_DB_RST;
    stale_after = TIMEOUT_RST;
  endtask

  task automatic write_reg();
    case (cfg_index)
      CFG_LIN_DB:  lin_band = cfg_wdata[DB_W-1:0];
      CFG_ANG_DB:  ang_band = cfg_wdata[DB_W-1:0];
      CFG_TIMEOUT: stale_after = cfg_wdata[AGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic take_request();
    result_t pick;
    vel6_t   v;
    int      i;
    v = '{in_mon.linear_x, in_mon.linear_y, in_mon.linear_z,
          in_mon.angular_x, in_mon.angular_y, in_mon.angular_z};
    case (in_mon.kind)
      KIND_CMD: begin
        if (int'(in_mon.src) < NUM_SOURCES &&
            (vel_mag(v.linear_x) > lin_band || vel_mag(v.angular_z) > ang_band)) begin
          src_vel[in_mon.src] = v;
          src_age[in_mon.src] = '0;
        end
      end
      KIND_TICK: begin
        for (i = 0; i < NUM_SOURCES; i++)
          if (src_age[i] != AGE_MAX) src_age[i] = src_age[i] + 1'b1;
      end
      KIND_PUBLISH: begin
        // walk from lowest priority up so the highest-priority fresh source wins
        pick = '0;
        for (i = NUM_SOURCES - 1; i >= 0; i--) begin
          if (src_age[i] < stale_after) begin
            pick.valid = 1'b1;
            pick.source = 2'(i);
            pick.vel = src_vel[i];
          end
        end
        publish_q.push_back(pick);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (publish_q.size() == 0) begin
      $error("result with no publish request waiting: out_source %0d", out_mon.out_source);
      mismatch_cnt++;
    end else begin
      want = publish_q.pop_front();
      check_field("out_valid", want.valid, out_mon.out_valid);
      check_field("out_source", want.source, out_mon.out_source);
      check_field("out_linear_x", want.vel.linear_x, out_mon.out_linear_x);
      check_field("out_linear_y", want.vel.linear_y, out_mon.out_linear_y);
      check_field("out_linear_z", want.vel.linear_z, out_mon.out_linear_z);
      check_field("out_angular_x", want.vel.angular_x, out_mon.out_angular_x);
      check_field("out_angular_y", want.vel.angular_y, out_mon.out_angular_y);
      check_field("out_angular_z", want.vel.angular_z, out_mon.out_angular_z);
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    publish_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sources();
      publish_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) write_reg();
      if (in_mon.valid && in_mon.ready) take_request();
    end
    publish_pending = publish_q.size();
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench: drives requests and register writes into the velocity command mux
// and reports the verdict from the checker's mismatch count
// depends on pvcm_pkg, pvcm_in_if, pvcm_out_if, pvcm_mux_checker and the mux core
`default_nettype none

module testbench;
  import pvcm_pkg::*;

  // kind code the block must drop
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  // margin after the last result for dropped requests still in flight
  localparam int DRAIN_CYCLES = 4;
  localparam vel_t VEL_MAX = 16'sh7fff;
  localparam vel_t VEL_MIN = 16'sh8000;
  localparam logic [DB_W-1:0] DB_MAX = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatch_cnt;
  int                   publish_pending;

  // idle switches for each side, redrawn now and then so some stretches run flat out
  bit                   in_idle;
  bit                   out_idle;

  // deadbands currently programmed, only used to aim command values at the band edge
  logic [DB_W-1:0]      cur_lin_db;
  logic [DB_W-1:0]      cur_ang_db;

  pvcm_in_if  in_chan ();
  pvcm_out_if out_chan ();

  priority_velocity_command_mux_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pvcm_mux_checker u_mux_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_cnt    (mismatch_cnt),
    .publish_pending (publish_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fully random six-component payload
  function automatic vel6_t rand_vel6();
    vel6_t v;
    v = {$urandom, $urandom, $urandom};
    return v;
  endfunction

  // value for a deadband-tested axis: random, right at the band edge, inside it, or extreme
  function automatic vel_t pick_axis(input logic [DB_W-1:0] db);
    int m;
    case ($urandom_range(0, 3))
      0: return vel_t'($urandom);
      1: begin
        // one below, at, or one above the band; above the top band wraps to most negative
        m = int'(db) + int'($urandom_range(0, 2)) - 1;
        if (m < 0) m = 0;
        return $urandom_range(0, 1) ? vel_t'(m) : vel_t'(-m);
      end
      2: return vel_t'($urandom_range(0, int'(db)));
      default: return $urandom_range(0, 1) ? VEL_MAX : VEL_MIN;
    endcase
  endfunction

  // random payload with the two deadband-tested axes set
  function automatic vel6_t with_axes(input vel_t lx, input vel_t az);
    vel6_t v;
    v = rand_vel6();
    v.linear_x = lx;
    v.angular_z = az;
    return v;
  endfunction

  // one request: optional idle gap, then hold valid until the block takes it
  task automatic send_request(input logic [1:0] kind, input logic [1:0] src, input vel6_t v);
    int gap;
    gap = in_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.src <= src;
    in_chan.linear_x <= v.linear_x;
    in_chan.linear_y <= v.linear_y;
    in_chan.linear_z <= v.linear_z;
    in_chan.angular_x <= v.angular_x;
    in_chan.angular_y <= v.angular_y;
    in_chan.angular_z <= v.angular_z;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // stop requesting, wait for every publish result, then let dropped requests settle
  task automatic drain_pending();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (publish_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic set_config(input logic [DB_W-1:0] lin_db, input logic [DB_W-1:0] ang_db,
                            input age_t tmo);
    drain_pending();
    write_reg(CFG_LIN_DB, CFG_W'(lin_db));
    write_reg(CFG_ANG_DB, CFG_W'(ang_db));
    write_reg(CFG_TIMEOUT, CFG_W'(tmo));
    cfg_we <= 1'b0;
    cur_lin_db = lin_db;
    cur_ang_db = ang_db;
  endtask

  // result side: random stall before each result, some stretches always ready
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin
    int         sent;
    int         reshuffle_at;
    int         roll;
    int         burst;
    logic [3:0] src_mask;
    logic [1:0] src;
    vel6_t      v;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.kind = '0;
    in_chan.src = '0;
    in_chan.linear_x = '0;
    in_chan.linear_y = '0;
    in_chan.linear_z = '0;
    in_chan.angular_x = '0;
    in_chan.angular_y = '0;
    in_chan.angular_z = '0;
    in_idle = 1'b1;
    out_idle = 1'b1;
    cur_lin_db = LIN_DB_RST;
    cur_ang_db = ANG_DB_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    // all sources start saturated: stale even against the largest timeout
    set_config(LIN_DB_RST, ANG_DB_RST, '1);
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    set_config(LIN_DB_RST, ANG_DB_RST, TIMEOUT_RST);
    // unused kind is dropped without a result
    send_request(KIND_UNUSED, 2'd1, rand_vel6());
    // magnitudes equal to the deadbands do not count
    send_request(KIND_CMD, 2'd2, with_axes(16'sd41, -16'sd41));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    // just above on linear x
    send_request(KIND_CMD, 2'd2, with_axes(16'sd42, 16'sd0));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    // most negative angular z always passes; lower priority than source 2
    send_request(KIND_CMD, 2'd3, with_axes(16'sd0, VEL_MIN));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    // highest priority with extreme values on the linear axes and angular x
    send_request(KIND_CMD, 2'd0, '{VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN, -16'sd1, 16'sd0});
    send_request(KIND_CMD, 2'd1, with_axes(-16'sd41, -16'sd42));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    send_request(KIND_TICK, 2'd3, rand_vel6());
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    // zero timeout: nothing is ever fresh
    set_config(LIN_DB_RST, ANG_DB_RST, '0);
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    // zero deadbands and the shortest timeout; ages are at one already
    set_config('0, '0, 16'd1);
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    send_request(KIND_CMD, 2'd1, with_axes(16'sd0, 16'sd0));
    send_request(KIND_CMD, 2'd3, with_axes(16'sd1, 16'sd0));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    send_request(KIND_TICK, 2'd0, rand_vel6());
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());
    send_request(KIND_CMD, 2'd0, with_axes(VEL_MIN, 16'sd0));
    send_request(KIND_PUBLISH, 2'd0, rand_vel6());

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(LIN_DB_RST, ANG_DB_RST, TIMEOUT_RST);
        1: set_config('0, '0, 16'd1);
        2: set_config(DB_MAX, DB_MAX, 16'd3);
        3: set_config(DB_W'($urandom), DB_W'($urandom), age_t'($urandom_range(2, 30)));
        4: set_config('0, DB_MAX, '0);
        5: set_config(DB_MAX, '0, '1);
        6: set_config(DB_W'($urandom_range(0, 600)), DB_W'($urandom_range(0, 600)),
                      age_t'($urandom_range(1, 10)));
        default: set_config(LIN_DB_RST, ANG_DB_RST, age_t'($urandom_range(10, 60)));
      endcase
      sent = 0;
      reshuffle_at = 0;
      while (sent < PHASE_ITEMS) begin
        // every so often change idling and which sources talk, so some go stale
        if (sent >= reshuffle_at) begin
          in_idle = $urandom_range(0, 3) != 0;
          out_idle = $urandom_range(0, 3) != 0;
          src_mask = 4'($urandom_range(1, 15));
          reshuffle_at += 40;
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          do src = 2'($urandom); while (!src_mask[src]);
          v = with_axes(pick_axis(cur_lin_db), pick_axis(cur_ang_db));
          send_request(KIND_CMD, src, v);
          sent++;
        end else if (roll < 70) begin
          // occasional tick bursts push sources past the timeout
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 30) : 1;
          repeat (burst) send_request(KIND_TICK, 2'($urandom), rand_vel6());
          sent += burst;
        end else if (roll < 95) begin
          send_request(KIND_PUBLISH, 2'($urandom), rand_vel6());
          sent++;
        end else begin
          send_request(KIND_UNUSED, 2'($urandom), rand_vel6());
          sent++;
        end
      end
    end

    drain_pending();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
